// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the turn controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, disabled while reset is held.
`define PDTC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication checked on a qualifying condition only.
`define PDTC_ASSERT_WHEN(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

`endif

// File: rtl/pdtc_pkg.sv
// ----------------------------------------------------------------------------
// pdtc_pkg
// Shared types, codes and helpers of the PD turn controller.
// ----------------------------------------------------------------------------
package pdtc_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_YAW    = 2'd2;

    // Turn sign and spin direction codes share one encoding.
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MARGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_WINDOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER   = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_PROP_GAIN   = 16'd2867;
    localparam logic [15:0] RST_DERIV_GAIN  = 16'd1533;
    localparam logic [7:0]  RST_VEL_SCALE   = 8'd10;
    localparam logic [5:0]  RST_SETTLE_LIM  = 6'd10;
    localparam logic [15:0] RST_BAND_MARGIN = 16'd2560;
    localparam logic [15:0] RST_HOLD_WINDOW = 16'd256;
    localparam logic [14:0] RST_MAX_POWER   = 15'd25600;

    // Angles in Q16.8 degrees, held at 26 bits for heading arithmetic.
    localparam logic signed [25:0] DEG180 = 26'sd46080;
    localparam logic signed [25:0] DEG360 = 26'sd92160;
    localparam logic signed [25:0] MAX24  = 26'sd8388607;
    localparam logic signed [25:0] MIN24  = -26'sd8388608;

    // Settle counter ceiling.
    localparam logic [5:0] CNT_MAX = 6'd63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval_en;
        logic step_p;
        logic step_d;
        logic step_sum;
        logic fin_en;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emits;
    } status_t;

    // Saturate a 26-bit signed value to the signed 24-bit range.
    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > MAX24) begin
            r = 24'sh7FFFFF;
        end else if (v < MIN24) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Magnitude of a signed 24-bit value; the most negative value fits unsigned.
    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        return v[23] ? 24'(-v) : 24'(v);
    endfunction

endpackage

// File: rtl/pdtc_ctrl.sv
// ----------------------------------------------------------------------------
// pdtc_ctrl
// Sequencer of the turn controller: handshakes and the multiply schedule.
// ----------------------------------------------------------------------------
module pdtc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pdtc_pkg::status_t status,
    output pdtc_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MULP = 3'd2;
    localparam logic [2:0] ST_MULD = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;
    logic       load;

    // The output register can take a result when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    cmd.eval_en = 1'b1;
                    state_next  = status.emits ? ST_IDLE : ST_MULP;
                end
            end
            ST_MULP: begin
                cmd.step_p = 1'b1;
                state_next = ST_MULD;
            end
            ST_MULD: begin
                cmd.step_d = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.step_sum = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.fin_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result is loaded either straight from evaluation or after the sum.
    assign load = (cmd.eval_en && status.emits) || cmd.fin_en;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/pdtc_datapath.sv
// ----------------------------------------------------------------------------
// pdtc_datapath
// Turn state, configuration registers, shared multiplier and result register.
// ----------------------------------------------------------------------------
module pdtc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pdtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_wdata,
    input  logic [1:0]                        s_op,
    input  logic signed [23:0]                s_value,
    input  pdtc_pkg::cmd_t                    cmd,
    output pdtc_pkg::status_t                 status,
    output logic [14:0]                       m_drive_power,
    output logic [1:0]                        m_direction,
    output logic                              m_hold_brake,
    output logic                              m_turn_done,
    output logic                              m_busy_res,
    output logic signed [23:0]                m_heading_correction
);

    // Configuration registers.
    logic [15:0] prop_gain_reg;
    logic [15:0] deriv_gain_reg;
    logic [7:0]  vel_scale_reg;
    logic [5:0]  settle_lim_reg;
    logic [15:0] band_margin_reg;
    logic [15:0] hold_window_reg;
    logic [14:0] max_power_reg;

    // Turn state.
    logic signed [23:0] target_reg;
    logic [23:0]        tmag_reg;
    logic signed [23:0] last_err_reg;
    logic [1:0]         sign_reg;
    logic [5:0]         cnt_reg;
    logic               holding_reg;
    logic               running_reg;
    logic signed [23:0] corr_reg;
    logic signed [23:0] heading_reg;

    // Captured item and intermediate values.
    logic [1:0]         op_reg;
    logic signed [23:0] val_reg;
    logic signed [23:0] err_reg;
    logic signed [24:0] diff_reg;
    logic [23:0]        kdv_reg;
    logic signed [50:0] prod_reg;
    logic signed [40:0] p1_reg;
    logic signed [50:0] acc_reg;

    // Evaluation signals.
    logic signed [25:0] val26;
    logic signed [25:0] tgt26;
    logic signed [25:0] corr26;
    logic signed [25:0] head26;
    logic signed [23:0] start_tgt;
    logic signed [23:0] err_now;
    logic [23:0]        aerr_now;
    logic signed [24:0] diff_now;
    logic signed [25:0] band_lim;
    logic               in_band;
    logic [5:0]         cnt_bump;
    logic               is_sample;
    logic               finish;
    logic signed [25:0] head_sum;
    logic signed [25:0] head_wrap;
    logic signed [23:0] yaw_corr;
    logic               running_after;
    logic signed [23:0] corr_after;

    // Multiplier operands.
    logic signed [24:0] mul_a;
    logic signed [25:0] mul_b;

    // Final power stage.
    logic [50:0]        acc_mag;
    logic [50:0]        acc_round;
    logic [38:0]        mag;
    logic [14:0]        power;
    logic [23:0]        aerr_fin;
    logic               hold_new;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= pdtc_pkg::RST_PROP_GAIN;
            deriv_gain_reg  <= pdtc_pkg::RST_DERIV_GAIN;
            vel_scale_reg   <= pdtc_pkg::RST_VEL_SCALE;
            settle_lim_reg  <= pdtc_pkg::RST_SETTLE_LIM;
            band_margin_reg <= pdtc_pkg::RST_BAND_MARGIN;
            hold_window_reg <= pdtc_pkg::RST_HOLD_WINDOW;
            max_power_reg   <= pdtc_pkg::RST_MAX_POWER;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pdtc_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                pdtc_pkg::REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata;
                pdtc_pkg::REG_VEL_SCALE:   vel_scale_reg   <= cfg_wdata[7:0];
                pdtc_pkg::REG_SETTLE_LIM:  settle_lim_reg  <= cfg_wdata[5:0];
                pdtc_pkg::REG_BAND_MARGIN: band_margin_reg <= cfg_wdata;
                pdtc_pkg::REG_HOLD_WINDOW: hold_window_reg <= cfg_wdata;
                pdtc_pkg::REG_MAX_POWER:   max_power_reg   <= cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // Item capture on the input transfer.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_op;
            val_reg <= s_value;
        end
    end

    // Sign-extended operands for the 24-bit adders.
    assign val26  = 26'(val_reg);
    assign tgt26  = 26'(target_reg);
    assign corr26 = 26'(corr_reg);
    assign head26 = 26'(heading_reg);

    // Start: target is the request plus the heading correction.
    assign start_tgt = pdtc_pkg::sat24(val26 + corr26);

    // Sample: error, its magnitude and its change since the last sample.
    assign err_now  = pdtc_pkg::sat24(tgt26 - val26);
    assign aerr_now = pdtc_pkg::abs24(err_now);
    assign diff_now = 25'(err_now) - 25'(last_err_reg);

    // Settle band is the target magnitude less the margin; it may be empty.
    assign band_lim = $signed({2'b00, tmag_reg}) - $signed({10'd0, band_margin_reg});
    assign in_band  = $signed({2'b00, aerr_now}) < band_lim;

    // Counter advances only while already holding, and saturates.
    always_comb begin
        if (!holding_reg) begin
            cnt_bump = '0;
        end else if (cnt_reg != pdtc_pkg::CNT_MAX) begin
            cnt_bump = cnt_reg + 6'd1;
        end else begin
            cnt_bump = cnt_reg;
        end
    end

    assign is_sample = (op_reg == pdtc_pkg::OP_SAMPLE) && running_reg;
    assign finish    = is_sample && in_band && (cnt_bump > settle_lim_reg);

    // Expected heading advances by the requested angle, wrapped to +-180.
    assign head_sum = head26 + tgt26 - corr26;
    always_comb begin
        if (head_sum > pdtc_pkg::DEG180) begin
            head_wrap = head_sum - pdtc_pkg::DEG360;
        end else if (head_sum < -pdtc_pkg::DEG180) begin
            head_wrap = head_sum + pdtc_pkg::DEG360;
        end else begin
            head_wrap = head_sum;
        end
    end

    // Yaw: correction is expected heading minus measured yaw.
    assign yaw_corr = pdtc_pkg::sat24(head26 - val26);

    // Only a sample of a running, unfinished turn goes on to the multiplier.
    assign status.emits = !is_sample || finish;

    // Busy flag and correction as they stand after this item.
    always_comb begin
        running_after = running_reg;
        corr_after    = corr_reg;
        case (op_reg)
            pdtc_pkg::OP_START: begin
                running_after = 1'b1;
            end
            pdtc_pkg::OP_SAMPLE: begin
                if (finish) begin
                    running_after = 1'b0;
                end
            end
            pdtc_pkg::OP_YAW: begin
                if (!running_reg) begin
                    corr_after = yaw_corr;
                end
            end
            default: begin
            end
        endcase
    end

    // Turn state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            tmag_reg     <= '0;
            last_err_reg <= '0;
            sign_reg     <= pdtc_pkg::SIGN_ZERO;
            cnt_reg      <= '0;
            holding_reg  <= 1'b0;
            running_reg  <= 1'b0;
            corr_reg     <= '0;
            heading_reg  <= '0;
        end else if (cmd.eval_en) begin
            case (op_reg)
                pdtc_pkg::OP_START: begin
                    target_reg   <= start_tgt;
                    tmag_reg     <= pdtc_pkg::abs24(start_tgt);
                    last_err_reg <= start_tgt;
                    if (start_tgt == '0) begin
                        sign_reg <= pdtc_pkg::SIGN_ZERO;
                    end else if (start_tgt[23]) begin
                        sign_reg <= pdtc_pkg::SIGN_NEG;
                    end else begin
                        sign_reg <= pdtc_pkg::SIGN_POS;
                    end
                    cnt_reg      <= '0;
                    holding_reg  <= 1'b0;
                    running_reg  <= 1'b1;
                end
                pdtc_pkg::OP_SAMPLE: begin
                    if (running_reg) begin
                        if (in_band) begin
                            cnt_reg <= cnt_bump;
                        end
                        if (finish) begin
                            heading_reg <= pdtc_pkg::sat24(head_wrap);
                            target_reg  <= '0;
                            running_reg <= 1'b0;
                        end
                    end
                end
                pdtc_pkg::OP_YAW: begin
                    if (!running_reg) begin
                        corr_reg <= yaw_corr;
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.fin_en) begin
            holding_reg  <= hold_new;
            last_err_reg <= err_reg;
        end
    end

    // Error and error change kept for the multiply sequence.
    always_ff @(posedge aclk) begin
        if (cmd.eval_en) begin
            err_reg  <= err_now;
            diff_reg <= diff_now;
        end
    end

    // Shared multiplier: kd*scale, then kp*error, then (kd*scale)*difference.
    always_comb begin
        if (cmd.step_p) begin
            mul_a = 25'(err_reg);
            mul_b = $signed({10'd0, prop_gain_reg});
        end else if (cmd.step_d) begin
            mul_a = diff_reg;
            mul_b = $signed({2'b00, kdv_reg});
        end else begin
            mul_a = $signed({9'd0, deriv_gain_reg});
            mul_b = $signed({18'd0, vel_scale_reg});
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.step_p) begin
            kdv_reg <= prod_reg[23:0];
        end
        if (cmd.step_d) begin
            p1_reg <= prod_reg[40:0];
        end
        if (cmd.step_sum) begin
            acc_reg <= 51'(p1_reg) + prod_reg;
        end
    end

    // Power magnitude rounded half up, then limited.
    assign acc_mag   = acc_reg[50] ? 51'(-acc_reg) : 51'(acc_reg);
    assign acc_round = acc_mag + 51'd2048;
    assign mag       = acc_round[50:12];
    assign power     = (mag > {24'd0, max_power_reg}) ? max_power_reg : mag[14:0];

    // Motors hold once the error falls inside the hold window.
    assign aerr_fin = pdtc_pkg::abs24(err_reg);
    assign hold_new = holding_reg || (aerr_fin < {8'd0, hold_window_reg});

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.eval_en && status.emits) begin
            m_drive_power        <= '0;
            m_direction          <= pdtc_pkg::SIGN_ZERO;
            m_hold_brake         <= 1'b0;
            m_turn_done          <= finish;
            m_busy_res           <= running_after;
            m_heading_correction <= corr_after;
        end else if (cmd.fin_en) begin
            m_drive_power        <= power;
            m_direction          <= sign_reg;
            m_hold_brake         <= hold_new;
            m_turn_done          <= 1'b0;
            m_busy_res           <= 1'b1;
            m_heading_correction <= corr_reg;
        end
    end

endmodule

// File: rtl/pd_turn_controller_unit.sv
// ----------------------------------------------------------------------------
// pd_turn_controller_unit
// PD turn regulator: start, gyro sample and yaw items, one result each.
// ----------------------------------------------------------------------------
// Start, yaw and idle items and samples that finish a turn load their result
// from evaluation; other samples of a running turn make three passes through
// the one shared multiplier, then the sum and the rounding stage. One item is
// in work at a time. Reset (aresetn low, synchronous) clears the turn state and
// loads the default gains and limits; no result is pending after reset.
`include "assert_macros.svh"

module pd_turn_controller_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pdtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic signed [23:0]             s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [14:0]                    m_drive_power,
    output logic [1:0]                     m_direction,
    output logic                           m_hold_brake,
    output logic                           m_turn_done,
    output logic                           m_busy_res,
    output logic signed [23:0]             m_heading_correction
);

    pdtc_pkg::cmd_t    cmd;
    pdtc_pkg::status_t status;

    // Sequencer.
    pdtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    pdtc_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_op                 (s_op),
        .s_value              (s_value),
        .cmd                  (cmd),
        .status               (status),
        .m_drive_power        (m_drive_power),
        .m_direction          (m_direction),
        .m_hold_brake         (m_hold_brake),
        .m_turn_done          (m_turn_done),
        .m_busy_res           (m_busy_res),
        .m_heading_correction (m_heading_correction)
    );

    // An accepted item occupies the block for at least the next cycle.
    `PDTC_ASSERT(a_busy_after_take, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready after transfer")
    // A finishing result brakes: no power, no spin, turn no longer running.
    `PDTC_ASSERT_WHEN(a_done_brakes, aclk, aresetn, m_valid && m_turn_done, (m_drive_power == 15'd0) && (m_direction == pdtc_pkg::SIGN_ZERO) && !m_busy_res, "done result not braking")
    // Holding and drive power appear only while a turn runs.
    `PDTC_ASSERT_WHEN(a_hold_running, aclk, aresetn, m_valid && (m_hold_brake || (m_drive_power != 15'd0)), m_busy_res, "hold or power while idle")
    // The sequencer issues at most one datapath command per cycle.
    `PDTC_ASSERT(a_one_cmd, aclk, aresetn, $onehot0(cmd), "overlapping commands")

endmodule
